/* hdl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	// Default width of a numerator; denominators are one bit narrower
	localparam int RAU_OPERAND_WIDTH = 16;

	// Width of the result fraction fields
	localparam int RES_WIDTH = 32;

	// Operation codes
	localparam int OP_WIDTH = 3;
	typedef logic [OP_WIDTH-1:0] op_t;

	localparam op_t OP_ADD = 3'd0;
	localparam op_t OP_SUB = 3'd1;
	localparam op_t OP_MUL = 3'd2;
	localparam op_t OP_DIV = 3'd3;
	localparam op_t OP_NEG = 3'd4;
	localparam op_t OP_INV = 3'd5;

endpackage

/* hdl/rau_req_if.sv */
// ----------------------------------------------------------------------------
// rau_req_if
// Request channel: operation code and the two operand fractions.
// ----------------------------------------------------------------------------
interface rau_req_if
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = RAU_OPERAND_WIDTH
) ();
	logic                            valid;
	logic                            ready;
	op_t                             op;
	logic signed [OPERAND_WIDTH-1:0] a_num;
	logic        [OPERAND_WIDTH-2:0] a_den;
	logic signed [OPERAND_WIDTH-1:0] b_num;
	logic        [OPERAND_WIDTH-2:0] b_den;

	modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
	modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

/* hdl/rau_rsp_if.sv */
// ----------------------------------------------------------------------------
// rau_rsp_if
// Response channel: result fraction and comparison flags.
// ----------------------------------------------------------------------------
interface rau_rsp_if
	import rau_pkg::*;
();
	logic                        valid;
	logic                        ready;
	logic signed [RES_WIDTH-1:0] res_num;
	logic signed [RES_WIDTH-1:0] res_den;
	logic                        den_zero;
	logic                        a_eq_b;
	logic                        a_gt_b;

	modport source (output valid, res_num, res_den, den_zero, a_eq_b, a_gt_b, input ready);
	modport sink   (input valid, res_num, res_den, den_zero, a_eq_b, a_gt_b, output ready);
endinterface

/* hdl/rau_div.sv */
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module rau_div #(
	parameter int WIDTH = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quotient
);
	localparam int CW = $clog2(WIDTH + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH:0]   rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dvs_q;

	logic [WIDTH:0]   rem_sh;
	logic [WIDTH:0]   diff;

	// Bring in the next dividend bit, trial-subtract the divisor
	assign rem_sh = {rem_q[WIDTH-1:0], quo_q[WIDTH-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[WIDTH]) begin
				rem_q <= diff;
				quo_q <= {quo_q[WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

/* hdl/rational_arith_unit_core.sv */
// ----------------------------------------------------------------------------
// rational_arith_unit_core
// Add, subtract, multiply, divide, negate or invert two fractions; the
// result is not reduced. Add and subtract scale to the LCM of the two
// denominators through a binary gcd and two quotients.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   op, a_num, a_den, b_num, b_den
//   rsp      out  valid/ready   res_num, res_den, den_zero, a_eq_b, a_gt_b
//
// One item at a time; req.ready is high only while the sequencer is idle.
// From the accepting edge to rsp.valid: div, neg, inv, unused codes and add or
// sub with a zero denominator pass the two cross products and the dispatch;
// mul also forms the numerator and denominator products. Other add and sub
// items also run the data-dependent gcd steps, the one-bit-per-cycle divider
// twice and the single shared multiplier.
// A finished result waits in the output register; the next item is taken
// while it waits, and the sequencer holds before writing it again.
// arst_n clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module rational_arith_unit_core
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = RAU_OPERAND_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	rau_req_if.sink   req,
	rau_rsp_if.source rsp
);
	localparam int W  = OPERAND_WIDTH;
	localparam int DW = OPERAND_WIDTH - 1;
	localparam int PW = 2 * OPERAND_WIDTH;
	localparam int KW = $clog2(OPERAND_WIDTH);

	typedef enum logic [4:0] {
		S_IDLE,
		S_CROSS_A,
		S_CROSS_B,
		S_DISPATCH,
		S_MUL_N,
		S_MUL_D,
		S_MUL_E,
		S_GCD,
		S_DIV_A,
		S_DIV_A_W,
		S_DIV_B,
		S_DIV_B_W,
		S_ADD_1,
		S_ADD_2,
		S_ADD_3,
		S_ADD_4,
		S_DONE
	} state_t;

	state_t state_q;

	op_t                 op_q;
	logic signed [W-1:0] an_q;
	logic        [DW-1:0] ad_q;
	logic signed [W-1:0] bn_q;
	logic        [DW-1:0] bd_q;

	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] lhs_q;
	logic        [DW-1:0] gx_q;
	logic        [DW-1:0] gy_q;
	logic        [KW-1:0] gk_q;
	logic        [DW-1:0] g_q;
	logic        [DW-1:0] qa_q;
	logic        [DW-1:0] qb_q;

	logic [RES_WIDTH-1:0] rn_q;
	logic [RES_WIDTH-1:0] rd_q;
	logic                 eq_q;
	logic                 gt_q;

	logic                        out_valid_q;
	logic signed [RES_WIDTH-1:0] res_num_q;
	logic signed [RES_WIDTH-1:0] res_den_q;
	logic                        den_zero_q;
	logic                        a_eq_b_q;
	logic                        a_gt_b_q;

	logic signed [W-1:0]  mul_a;
	logic signed [W-1:0]  mul_b;
	logic signed [63:0]   prod_ext;
	logic signed [63:0]   lhs_ext;
	logic [RES_WIDTH-1:0] prod_lo;
	logic [RES_WIDTH-1:0] an_ext;
	logic [RES_WIDTH-1:0] ad_ext;

	logic          div_start;
	logic [DW-1:0] div_dividend;
	logic          div_done;
	logic [DW-1:0] div_quo;

	assign prod_ext = 64'(prod_q);
	assign lhs_ext  = 64'(lhs_q);
	assign prod_lo  = prod_ext[RES_WIDTH-1:0];
	assign an_ext   = RES_WIDTH'(an_q);
	assign ad_ext   = RES_WIDTH'(ad_q);

	// Operand select of the shared multiplier
	always_comb begin
		unique case (state_q)
			S_CROSS_A: begin
				mul_a = an_q;
				mul_b = signed'({1'b0, bd_q});
			end
			S_CROSS_B: begin
				mul_a = bn_q;
				mul_b = signed'({1'b0, ad_q});
			end
			S_MUL_N: begin
				mul_a = an_q;
				mul_b = bn_q;
			end
			S_MUL_D: begin
				mul_a = signed'({1'b0, ad_q});
				mul_b = signed'({1'b0, bd_q});
			end
			S_ADD_1: begin
				mul_a = an_q;
				mul_b = signed'({1'b0, qb_q});
			end
			S_ADD_2: begin
				mul_a = bn_q;
				mul_b = signed'({1'b0, qa_q});
			end
			S_ADD_3: begin
				mul_a = signed'({1'b0, qa_q});
				mul_b = signed'({1'b0, bd_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign div_start    = (state_q == S_DIV_A) || (state_q == S_DIV_B);
	assign div_dividend = (state_q == S_DIV_A) ? ad_q : bd_q;

	rau_div #(
		.WIDTH (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (g_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			op_q        <= OP_ADD;
			an_q        <= '0;
			ad_q        <= '0;
			bn_q        <= '0;
			bd_q        <= '0;
			lhs_q       <= '0;
			gx_q        <= '0;
			gy_q        <= '0;
			gk_q        <= '0;
			g_q         <= '0;
			qa_q        <= '0;
			qb_q        <= '0;
			rn_q        <= '0;
			rd_q        <= '0;
			eq_q        <= 1'b0;
			gt_q        <= 1'b0;
			res_num_q   <= '0;
			res_den_q   <= '0;
			den_zero_q  <= 1'b0;
			a_eq_b_q    <= 1'b0;
			a_gt_b_q    <= 1'b0;
		end else begin
			// Drop the output item once taken, unless a new one is written now
			if (rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.op;
						an_q    <= req.a_num;
						ad_q    <= req.a_den;
						bn_q    <= req.b_num;
						bd_q    <= req.b_den;
						state_q <= S_CROSS_A;
					end
				end
				S_CROSS_A: begin
					state_q <= S_CROSS_B;
				end
				S_CROSS_B: begin
					lhs_q   <= prod_q;
					state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					// prod_q holds b_num * a_den here
					eq_q <= (lhs_q == prod_q);
					gt_q <= (lhs_q > prod_q);
					case (op_q) inside
						OP_ADD, OP_SUB: begin
							if (ad_q == '0 || bd_q == '0) begin
								rn_q    <= '0;
								rd_q    <= '0;
								state_q <= S_DONE;
							end else begin
								gx_q    <= ad_q;
								gy_q    <= bd_q;
								gk_q    <= '0;
								state_q <= S_GCD;
							end
						end
						OP_MUL: begin
							state_q <= S_MUL_N;
						end
						OP_DIV: begin
							rn_q    <= lhs_ext[RES_WIDTH-1:0];
							rd_q    <= prod_lo;
							state_q <= S_DONE;
						end
						OP_NEG: begin
							rn_q    <= -an_ext;
							rd_q    <= ad_ext;
							state_q <= S_DONE;
						end
						OP_INV: begin
							rn_q    <= ad_ext;
							rd_q    <= an_ext;
							state_q <= S_DONE;
						end
						default: begin
							rn_q    <= an_ext;
							rd_q    <= ad_ext;
							state_q <= S_DONE;
						end
					endcase
				end
				S_MUL_N: begin
					state_q <= S_MUL_D;
				end
				S_MUL_D: begin
					rn_q    <= prod_lo;
					state_q <= S_MUL_E;
				end
				S_MUL_E: begin
					rd_q    <= prod_lo;
					state_q <= S_DONE;
				end
				S_GCD: begin
					// Binary gcd: strip common twos, then subtract odd from odd
					if (gx_q == gy_q) begin
						g_q     <= DW'(gx_q << gk_q);
						state_q <= S_DIV_A;
					end else if (!gx_q[0] && !gy_q[0]) begin
						gx_q <= gx_q >> 1;
						gy_q <= gy_q >> 1;
						gk_q <= gk_q + 1'b1;
					end else if (!gx_q[0]) begin
						gx_q <= gx_q >> 1;
					end else if (!gy_q[0]) begin
						gy_q <= gy_q >> 1;
					end else if (gx_q > gy_q) begin
						gx_q <= gx_q - gy_q;
					end else begin
						gy_q <= gy_q - gx_q;
					end
				end
				S_DIV_A: begin
					state_q <= S_DIV_A_W;
				end
				S_DIV_A_W: begin
					if (div_done) begin
						qa_q    <= div_quo;
						state_q <= S_DIV_B;
					end
				end
				S_DIV_B: begin
					state_q <= S_DIV_B_W;
				end
				S_DIV_B_W: begin
					if (div_done) begin
						qb_q    <= div_quo;
						state_q <= S_ADD_1;
					end
				end
				S_ADD_1: begin
					state_q <= S_ADD_2;
				end
				S_ADD_2: begin
					rn_q    <= prod_lo;
					state_q <= S_ADD_3;
				end
				S_ADD_3: begin
					rn_q    <= (op_q == OP_SUB) ? rn_q - prod_lo : rn_q + prod_lo;
					state_q <= S_ADD_4;
				end
				S_ADD_4: begin
					rd_q    <= prod_lo;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// Hold until the output register is free
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						res_num_q   <= rn_q;
						res_den_q   <= rd_q;
						den_zero_q  <= (rd_q == '0);
						a_eq_b_q    <= eq_q;
						a_gt_b_q    <= gt_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready    = (state_q == S_IDLE);
	assign rsp.valid    = out_valid_q;
	assign rsp.res_num  = res_num_q;
	assign rsp.res_den  = res_den_q;
	assign rsp.den_zero = den_zero_q;
	assign rsp.a_eq_b   = a_eq_b_q;
	assign rsp.a_gt_b   = a_gt_b_q;
endmodule

/* hdl/rau_checker.sv */
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module rau_checker
	import rau_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [RES_WIDTH-1:0] res_den,
	input logic                 den_zero,
	input logic                 a_eq_b,
	input logic                 a_gt_b
);
	// An accepted item occupies the unit for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req.ready high right after an accepted item");

	// No result can appear in the cycle right after an accept
	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> !rsp_valid)
		else $error("rsp.valid rose one cycle after accept");

	a_den_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (den_zero == (res_den == '0)))
		else $error("den_zero disagrees with res_den");

	a_cmp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(a_eq_b && a_gt_b))
		else $error("a_eq_b and a_gt_b both set");

	a_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(res_den))
		else $error("stalled result dropped or changed");
endmodule

bind rational_arith_unit_core rau_checker u_rau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.res_den   (rsp.res_den),
	.den_zero  (rsp.den_zero),
	.a_eq_b    (rsp.a_eq_b),
	.a_gt_b    (rsp.a_gt_b)
);
